// ===== rtl/tph_pkg.sv =====
// ----------------------------------------------------------------------------
// tph_pkg
// Shared types, codes and the microcode table for the sensor compensation
// block: datapath operation codes, multiplier phases and the control bundle.
// ----------------------------------------------------------------------------
package tph_pkg;

  // Reading kinds carried by the action field
  localparam logic [1:0] ACT_TEMP  = 2'd0;
  localparam logic [1:0] ACT_PRESS = 2'd1;
  localparam logic [1:0] ACT_HUM   = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_TEMP     = 3'd0;
  localparam logic [2:0] REG_PRESS_LO = 3'd1;
  localparam logic [2:0] REG_PRESS_HI = 3'd2;
  localparam logic [2:0] REG_PRESS_P9 = 3'd3;
  localparam logic [2:0] REG_HUM_A    = 3'd4;
  localparam logic [2:0] REG_HUM_B    = 3'd5;

  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PC_TEMP  = 5'd0;
  localparam logic [PC_W-1:0] PC_PRESS = 5'd5;
  localparam logic [PC_W-1:0] PC_HUM   = 5'd20;

  localparam logic [31:0] HUM_MAX = 32'd419430400;

  // Datapath operations, one per program step
  typedef enum logic [5:0] {
    OP_NOP = 6'd0,
    OP_T0  = 6'd1,  OP_T1  = 6'd2,  OP_T2  = 6'd3,  OP_T3  = 6'd4,  OP_T4  = 6'd5,
    OP_P0  = 6'd6,  OP_P1  = 6'd7,  OP_P2  = 6'd8,  OP_P3  = 6'd9,  OP_P4  = 6'd10,
    OP_P5  = 6'd11, OP_P6  = 6'd12, OP_P7  = 6'd13, OP_P8  = 6'd14, OP_P9  = 6'd15,
    OP_P10 = 6'd16, OP_P11 = 6'd17, OP_P12 = 6'd18, OP_P13 = 6'd19, OP_P14 = 6'd20,
    OP_H0  = 6'd21, OP_H1  = 6'd22, OP_H2  = 6'd23, OP_H3  = 6'd24, OP_H4  = 6'd25,
    OP_H5  = 6'd26, OP_H6  = 6'd27, OP_H7  = 6'd28, OP_H8  = 6'd29, OP_H9  = 6'd30
  } op_t;

  // Partial product phases of the 64-bit wrapping multiply
  typedef enum logic [1:0] {
    MPH_LL = 2'd0,
    MPH_LH = 2'd1,
    MPH_HL = 2'd2
  } mph_t;

  // One program step: the operation and what follows it
  typedef struct packed {
    op_t  op;
    logic mul;
    logic div;
    logic last;
  } ucode_t;

  // Control bundle from the controller to the datapath
  typedef struct packed {
    op_t  op;
    logic mul_en;
    mph_t mph;
    logic div_step;
    logic load_in;
    logic load_out;
  } cmd_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int s);
    asr32 = 32'($signed(x) >>> s);
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int s);
    asr64 = 64'($signed(x) >>> s);
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] v);
    sx16 = {{48{v[15]}}, v};
  endfunction

  // Program store: temperature, pressure and humidity sequences
  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    case (pc)
      5'd0:    ucode = '{OP_T0,  1'b1, 1'b0, 1'b0};
      5'd1:    ucode = '{OP_T1,  1'b1, 1'b0, 1'b0};
      5'd2:    ucode = '{OP_T2,  1'b1, 1'b0, 1'b0};
      5'd3:    ucode = '{OP_T3,  1'b0, 1'b0, 1'b0};
      5'd4:    ucode = '{OP_T4,  1'b0, 1'b0, 1'b1};
      5'd5:    ucode = '{OP_P0,  1'b1, 1'b0, 1'b0};
      5'd6:    ucode = '{OP_P1,  1'b1, 1'b0, 1'b0};
      5'd7:    ucode = '{OP_P2,  1'b1, 1'b0, 1'b0};
      5'd8:    ucode = '{OP_P3,  1'b1, 1'b0, 1'b0};
      5'd9:    ucode = '{OP_P4,  1'b1, 1'b0, 1'b0};
      5'd10:   ucode = '{OP_P5,  1'b0, 1'b0, 1'b0};
      5'd11:   ucode = '{OP_P6,  1'b1, 1'b0, 1'b0};
      5'd12:   ucode = '{OP_P7,  1'b1, 1'b0, 1'b0};
      5'd13:   ucode = '{OP_P8,  1'b0, 1'b1, 1'b0};
      5'd14:   ucode = '{OP_P9,  1'b1, 1'b0, 1'b0};
      5'd15:   ucode = '{OP_P10, 1'b1, 1'b0, 1'b0};
      5'd16:   ucode = '{OP_P11, 1'b1, 1'b0, 1'b0};
      5'd17:   ucode = '{OP_P12, 1'b0, 1'b0, 1'b0};
      5'd18:   ucode = '{OP_P13, 1'b0, 1'b0, 1'b0};
      5'd19:   ucode = '{OP_P14, 1'b0, 1'b0, 1'b1};
      5'd20:   ucode = '{OP_H0,  1'b1, 1'b0, 1'b0};
      5'd21:   ucode = '{OP_H1,  1'b1, 1'b0, 1'b0};
      5'd22:   ucode = '{OP_H2,  1'b1, 1'b0, 1'b0};
      5'd23:   ucode = '{OP_H3,  1'b1, 1'b0, 1'b0};
      5'd24:   ucode = '{OP_H4,  1'b1, 1'b0, 1'b0};
      5'd25:   ucode = '{OP_H5,  1'b1, 1'b0, 1'b0};
      5'd26:   ucode = '{OP_H6,  1'b1, 1'b0, 1'b0};
      5'd27:   ucode = '{OP_H7,  1'b1, 1'b0, 1'b0};
      5'd28:   ucode = '{OP_H8,  1'b0, 1'b0, 1'b0};
      5'd29:   ucode = '{OP_H9,  1'b0, 1'b0, 1'b1};
      default: ucode = '{OP_NOP, 1'b0, 1'b0, 1'b1};
    endcase
  endfunction

endpackage

// ===== rtl/tph_ctrl.sv =====
// ----------------------------------------------------------------------------
// tph_ctrl
// Sequencer: accepts an item, steps through the program for its reading
// kind, runs multiplier phases and divider iterations, hands off the result.
// ----------------------------------------------------------------------------
module tph_ctrl
  import tph_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  output logic       out_valid,
  input  logic       out_stall,
  output cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_WAIT = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  mph_t            mph_r, mph_nxt;
  logic [5:0]      cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  ucode_t          uc;
  logic            in_acc;

  assign uc        = ucode(pc_r);
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and command decode
  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    mph_nxt       = mph_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '{OP_NOP, 1'b0, MPH_LL, 1'b0, 1'b0, 1'b0};
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd.load_in = 1'b1;
          case (in_action)
            ACT_TEMP:  begin pc_nxt = PC_TEMP;  state_nxt = S_EXEC; end
            ACT_PRESS: begin pc_nxt = PC_PRESS; state_nxt = S_EXEC; end
            ACT_HUM:   begin pc_nxt = PC_HUM;   state_nxt = S_EXEC; end
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_EXEC: begin
        cmd.op = uc.op;
        if (uc.mul) begin
          mph_nxt   = MPH_LL;
          state_nxt = S_MUL;
        end else if (uc.div) begin
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else if (uc.last) begin
          state_nxt = S_WAIT;
        end else begin
          pc_nxt = pc_r + 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.mph    = mph_r;
        case (mph_r)
          MPH_LL:  mph_nxt = MPH_LH;
          MPH_LH:  mph_nxt = MPH_HL;
          default: begin
            pc_nxt    = pc_r + 1'b1;
            state_nxt = S_EXEC;
          end
        endcase
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == 6'd63) begin
          pc_nxt    = pc_r + 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_WAIT: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      mph_r       <= MPH_LL;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      mph_r       <= mph_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/tph_dpath.sv =====
// ----------------------------------------------------------------------------
// tph_dpath
// Datapath: calibration registers, fine temperature, working registers,
// a shared 32x32 multiplier built into a 64-bit wrapping multiply over three
// phases, a radix-2 signed 64-bit divider and the output register.
// ----------------------------------------------------------------------------
module tph_dpath
  import tph_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic [19:0] in_raw_reading,
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic [32:0] out_compensated_value
);

  logic [47:0] temp_calib_r;
  logic [63:0] press_lo_r, press_hi_r;
  logic [15:0] press_p9_r;
  logic [31:0] hum_a_r, hum_b_r;

  logic [31:0] ft_r, ft_nxt;
  logic [19:0] raw_r, raw_nxt;
  logic [63:0] ma_r, ma_nxt, mb_r, mb_nxt, mp_r, mp_nxt;
  logic [63:0] t0_r, t0_nxt, t1_r, t1_nxt, t2_r, t2_nxt, t3_r, t3_nxt;
  logic        zero_r, zero_nxt, neg_r, neg_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt, den_r, den_nxt;
  logic [32:0] res_r, res_nxt, out_r, out_nxt;

  // calibration fields
  logic [31:0] t1c, t2c, t3c;
  logic [31:0] h1c, h2c, h3c, h4c, h5c, h6c;
  logic [63:0] p1c, p2c, p3c, p4c, p5c, p6c, p7c, p8c, p9c;

  logic [31:0] p32, mul_a, mul_b, tmp32, xh;
  logic [63:0] prod, tmp64, q_signed;
  logic [64:0] rem_sh, diff;

  assign t1c = {16'b0, temp_calib_r[15:0]};
  assign t2c = {{16{temp_calib_r[31]}}, temp_calib_r[31:16]};
  assign t3c = {{16{temp_calib_r[47]}}, temp_calib_r[47:32]};
  assign p1c = {48'b0, press_lo_r[15:0]};
  assign p2c = sx16(press_lo_r[31:16]);
  assign p3c = sx16(press_lo_r[47:32]);
  assign p4c = sx16(press_lo_r[63:48]);
  assign p5c = sx16(press_hi_r[15:0]);
  assign p6c = sx16(press_hi_r[31:16]);
  assign p7c = sx16(press_hi_r[47:32]);
  assign p8c = sx16(press_hi_r[63:48]);
  assign p9c = sx16(press_p9_r);
  assign h1c = {24'b0, hum_a_r[7:0]};
  assign h2c = {{16{hum_a_r[23]}}, hum_a_r[23:8]};
  assign h3c = {24'b0, hum_a_r[31:24]};
  assign h4c = {{20{hum_b_r[11]}}, hum_b_r[11:0]};
  assign h5c = {{20{hum_b_r[23]}}, hum_b_r[23:12]};
  assign h6c = {{24{hum_b_r[31]}}, hum_b_r[31:24]};

  assign p32 = mp_r[31:0];

  // Shared multiplier: pick the 32-bit halves for this phase
  always_comb begin
    case (cmd.mph)
      MPH_LL:  begin mul_a = ma_r[31:0];  mul_b = mb_r[31:0];  end
      MPH_LH:  begin mul_a = ma_r[31:0];  mul_b = mb_r[63:32]; end
      MPH_HL:  begin mul_a = ma_r[63:32]; mul_b = mb_r[31:0];  end
      default: begin mul_a = ma_r[31:0];  mul_b = mb_r[31:0];  end
    endcase
  end
  assign prod = {32'b0, mul_a} * {32'b0, mul_b};

  // Divider: shift in one quotient bit per cycle
  assign rem_sh   = {rem_r[63:0], quo_r[63]};
  assign diff     = rem_sh - {1'b0, den_r};
  assign q_signed = neg_r ? (64'd0 - quo_r) : quo_r;

  always_comb begin
    ft_nxt   = ft_r;
    raw_nxt  = raw_r;
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    mp_nxt   = mp_r;
    t0_nxt   = t0_r;
    t1_nxt   = t1_r;
    t2_nxt   = t2_r;
    t3_nxt   = t3_r;
    zero_nxt = zero_r;
    neg_nxt  = neg_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    res_nxt  = res_r;
    out_nxt  = out_r;
    tmp32    = '0;
    tmp64    = '0;
    xh       = '0;

    if (cmd.load_in) begin
      raw_nxt = in_raw_reading;
    end
    if (cmd.load_out) begin
      out_nxt = res_r;
    end

    // accumulate the partial products
    if (cmd.mul_en) begin
      if (cmd.mph == MPH_LL) begin
        mp_nxt = prod;
      end else begin
        mp_nxt = mp_r + {prod[31:0], 32'b0};
      end
    end

    if (cmd.div_step) begin
      if (!diff[64]) begin
        rem_nxt = diff;
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
    end

    case (cmd.op)
      // temperature, 32-bit wrapping
      OP_T0: begin
        ma_nxt = {32'b0, 32'(raw_r >> 3) - (t1c << 1)};
        mb_nxt = {32'b0, t2c};
      end
      OP_T1: begin
        t0_nxt = {32'b0, asr32(p32, 11)};
        tmp32  = 32'(raw_r >> 4) - t1c;
        ma_nxt = {32'b0, tmp32};
        mb_nxt = {32'b0, tmp32};
      end
      OP_T2: begin
        ma_nxt = {32'b0, asr32(p32, 12)};
        mb_nxt = {32'b0, t3c};
      end
      OP_T3: ft_nxt = t0_r[31:0] + asr32(p32, 14);
      OP_T4: begin
        tmp32   = asr32((ft_r << 2) + ft_r + 32'd128, 8);
        res_nxt = {tmp32[31], tmp32};
      end
      // pressure, 64-bit wrapping
      OP_P0: begin
        tmp64  = {{32{ft_r[31]}}, ft_r} - 64'd128000;
        t0_nxt = tmp64;
        ma_nxt = tmp64;
        mb_nxt = tmp64;
      end
      OP_P1: begin
        t1_nxt = mp_r;
        ma_nxt = mp_r;
        mb_nxt = p6c;
      end
      OP_P2: begin
        t2_nxt = mp_r;
        ma_nxt = t0_r;
        mb_nxt = p5c;
      end
      OP_P3: begin
        t2_nxt = t2_r + (mp_r << 17);
        ma_nxt = t1_r;
        mb_nxt = p3c;
      end
      OP_P4: begin
        t2_nxt = t2_r + (p4c << 35);
        t3_nxt = asr64(mp_r, 8);
        ma_nxt = t0_r;
        mb_nxt = p2c;
      end
      OP_P5: t3_nxt = t3_r + (mp_r << 12);
      OP_P6: begin
        ma_nxt = 64'h0000_8000_0000_0000 + t3_r;
        mb_nxt = p1c;
      end
      OP_P7: begin
        tmp64    = asr64(mp_r, 33);
        t3_nxt   = tmp64;
        zero_nxt = (tmp64 == 64'd0);
        ma_nxt   = ((64'd1048576 - {44'b0, raw_r}) << 31) - t2_r;
        mb_nxt   = 64'd3125;
      end
      OP_P8: begin
        // load the divider with magnitudes and the quotient sign
        neg_nxt = mp_r[63] ^ t3_r[63];
        quo_nxt = mp_r[63] ? (64'd0 - mp_r) : mp_r;
        den_nxt = t3_r[63] ? (64'd0 - t3_r) : t3_r;
        rem_nxt = '0;
      end
      OP_P9: begin
        t0_nxt = q_signed;
        ma_nxt = p9c;
        mb_nxt = asr64(q_signed, 13);
      end
      OP_P10: begin
        ma_nxt = mp_r;
        mb_nxt = asr64(t0_r, 13);
      end
      OP_P11: begin
        t1_nxt = asr64(mp_r, 25);
        ma_nxt = p8c;
        mb_nxt = t0_r;
      end
      OP_P12: t1_nxt = t1_r + asr64(mp_r, 19);
      OP_P13: t0_nxt = t0_r + t1_r;
      OP_P14: begin
        tmp64   = asr64(t0_r, 8) + (p7c << 4);
        res_nxt = zero_r ? 33'd0 : {1'b0, tmp64[31:0]};
      end
      // humidity, 32-bit wrapping
      OP_H0: begin
        tmp32  = ft_r - 32'd76800;
        t0_nxt = {32'b0, tmp32};
        ma_nxt = {32'b0, tmp32};
        mb_nxt = {32'b0, h5c};
      end
      OP_H1: begin
        tmp32  = ({16'b0, raw_r[15:0]} << 14) - (h4c << 20) - p32 + 32'd16384;
        t1_nxt = {32'b0, asr32(tmp32, 15)};
        ma_nxt = t0_r;
        mb_nxt = {32'b0, h6c};
      end
      OP_H2: begin
        t2_nxt = {32'b0, asr32(p32, 10)};
        ma_nxt = t0_r;
        mb_nxt = {32'b0, h3c};
      end
      OP_H3: begin
        ma_nxt = t2_r;
        mb_nxt = {32'b0, asr32(p32, 11) + 32'd32768};
      end
      OP_H4: begin
        ma_nxt = {32'b0, asr32(p32, 10) + 32'd2097152};
        mb_nxt = {32'b0, h2c};
      end
      OP_H5: begin
        ma_nxt = t1_r;
        mb_nxt = {32'b0, asr32(p32 + 32'd8192, 14)};
      end
      OP_H6: begin
        t0_nxt = {32'b0, p32};
        tmp32  = asr32(p32, 15);
        ma_nxt = {32'b0, tmp32};
        mb_nxt = {32'b0, tmp32};
      end
      OP_H7: begin
        ma_nxt = {32'b0, asr32(p32, 7)};
        mb_nxt = {32'b0, h1c};
      end
      OP_H8: t0_nxt = {32'b0, t0_r[31:0] - asr32(p32, 4)};
      OP_H9: begin
        // clamp to the valid range, then drop the extra fraction bits
        xh = t0_r[31:0];
        if (xh[31]) begin
          xh = '0;
        end else if (xh > HUM_MAX) begin
          xh = HUM_MAX;
        end
        res_nxt = {13'b0, xh[31:12]};
      end
      default: ;
    endcase
  end

  // Configuration registers and fine temperature
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_calib_r <= '0;
      press_lo_r   <= '0;
      press_hi_r   <= '0;
      press_p9_r   <= '0;
      hum_a_r      <= '0;
      hum_b_r      <= '0;
      ft_r         <= '0;
    end else begin
      ft_r <= ft_nxt;
      if (cfg_write_en) begin
        case (cfg_index)
          REG_TEMP:     temp_calib_r <= cfg_data[47:0];
          REG_PRESS_LO: press_lo_r   <= cfg_data;
          REG_PRESS_HI: press_hi_r   <= cfg_data;
          REG_PRESS_P9: press_p9_r   <= cfg_data[15:0];
          REG_HUM_A:    hum_a_r      <= cfg_data[31:0];
          REG_HUM_B:    hum_b_r      <= cfg_data[31:0];
          default: ;
        endcase
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    raw_r  <= raw_nxt;
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    mp_r   <= mp_nxt;
    t0_r   <= t0_nxt;
    t1_r   <= t1_nxt;
    t2_r   <= t2_nxt;
    t3_r   <= t3_nxt;
    zero_r <= zero_nxt;
    neg_r  <= neg_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    den_r  <= den_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  assign out_compensated_value = out_r;

endmodule

// ===== rtl/tph_sensor_compensation.sv =====
// One item at a time: the next item is accepted in the cycle after the result
// is handed to the output register.
// Each multiply runs on the shared 32x32 multiplier in its LL, LH and HL phases;
// the pressure divide produces one quotient bit a cycle.
// Reset (synchronous, active low) clears control, calibration registers and
// the fine temperature; the block accepts items as soon as reset is released.
// ----------------------------------------------------------------------------
// tph_sensor_compensation
// Temperature, pressure and humidity compensation of raw converter readings
// using calibration words written over a simple register port.
// ----------------------------------------------------------------------------
module tph_sensor_compensation
  import tph_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [19:0] in_raw_reading,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [32:0] out_compensated_value,
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cmd_t cmd;

  tph_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  tph_dpath u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .in_raw_reading        (in_raw_reading),
    .cfg_write_en          (cfg_write_en),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .out_compensated_value (out_compensated_value)
  );

endmodule

// ===== rtl/tph_checker.sv =====
// ----------------------------------------------------------------------------
// tph_checker
// Port-level checks of the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
module tph_checker
  import tph_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_action,
  input logic        out_valid,
  input logic        out_stall,
  input logic [32:0] out_compensated_value
);

  // come out of reset ready and empty
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!in_stall && !out_valid))
    else $error("block not idle after reset");

  // a real reading keeps the input side busy while it is worked
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_action != ACT_NONE)) |=> in_stall)
    else $error("input taken again before the item was worked");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_compensated_value)))
    else $error("stalled result dropped or changed");

endmodule

bind tph_sensor_compensation tph_checker u_tph_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_valid),
  .in_stall              (in_stall),
  .in_action             (in_action),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_compensated_value (out_compensated_value)
);
